[hdl/crsc_pkg.sv]
// crsc_pkg: widths, reset values and controller/datapath command and status
// types for the card repeat suppression cache. No dependencies.
`timescale 1ns / 1ps
package crsc_pkg;

  localparam int CARD_W         = 56;
  localparam int TIME_W         = 64;
  localparam int WIN_W          = 24;
  localparam int CACHE_ENTRIES_DEF = 8;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 24'd2000;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // capture the incoming request
    logic step;         // advance the cache read index
    logic capture;      // hold elapsed time and slot of a match
    logic wr_hit;       // refresh time of the matched slot
    logic wr_miss;      // write new entry at the replace pointer
    logic post;         // load the result register
    logic post_accept;
    logic post_cached;
  } crsc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic match;        // slot under compare is valid and holds the card
    logic last;         // slot under compare is the last one
    logic too_soon;     // elapsed time is below the window
    logic out_busy;     // result register still holds an untaken result
  } crsc_sts_t;

endpackage

[hdl/crsc_ifs.sv]
// crsc interfaces: valid/ready channels for scan requests, results and
// window configuration. Depends on crsc_pkg.
`timescale 1ns / 1ps
interface crsc_scan_if;
  import crsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CARD_W-1:0] card_id;
  logic [TIME_W-1:0] timestamp_ms;
  modport source (output valid, output card_id, output timestamp_ms, input ready);
  modport sink   (input valid, input card_id, input timestamp_ms, output ready);
endinterface

interface crsc_result_if;
  logic valid;
  logic ready;
  logic accept;
  logic was_cached;
  modport source (output valid, output accept, output was_cached, input ready);
  modport sink   (input valid, input accept, input was_cached, output ready);
endinterface

interface crsc_cfg_if;
  import crsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] debounce_window_ms;
  modport source (output valid, output debounce_window_ms, input ready);
  modport sink   (input valid, input debounce_window_ms, output ready);
endinterface

[hdl/crsc_ram.sv]
// crsc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module crsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/crsc_ctrl.sv]
// crsc_ctrl: request sequencer for the cache scan, decision and write-back.
// Depends on crsc_pkg.
`timescale 1ns / 1ps
module crsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  crsc_pkg::crsc_sts_t  sts,
  output crsc_pkg::crsc_cmd_t  cmd
);
  import crsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_SCAN,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_accept;
  logic   res_cached;
  logic   res_accept_next;
  logic   res_cached_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next      = state;
    res_accept_next = res_accept;
    res_cached_next = res_cached;
    cmd             = '0;
    cmd.post_accept = res_accept;
    cmd.post_cached = res_cached;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PRIME;
        end
      end
      S_PRIME: begin
        // first read is in flight
        cmd.step   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        priority if (sts.match) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end else if (sts.last) begin
          cmd.wr_miss     = 1'b1;
          res_accept_next = 1'b1;
          res_cached_next = 1'b0;
          state_next      = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_CHECK: begin
        res_cached_next = 1'b1;
        if (sts.too_soon) begin
          res_accept_next = 1'b0;
        end else begin
          cmd.wr_hit      = 1'b1;
          res_accept_next = 1'b1;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_accept <= 1'b0;
      res_cached <= 1'b0;
    end else begin
      state      <= state_next;
      res_accept <= res_accept_next;
      res_cached <= res_cached_next;
    end
  end

endmodule

[hdl/crsc_dp.sv]
// crsc_dp: cache storage, compare, elapsed-time check, replace pointer,
// window register and result register. Depends on crsc_pkg and crsc_ram.
`timescale 1ns / 1ps
module crsc_dp #(
  parameter int CACHE_ENTRIES = crsc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [crsc_pkg::CARD_W-1:0]   card_id,
  input  logic [crsc_pkg::TIME_W-1:0]   timestamp_ms,
  input  logic                          cfg_valid,
  input  logic [crsc_pkg::WIN_W-1:0]    cfg_window,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accept,
  output logic                          out_cached,
  input  crsc_pkg::crsc_cmd_t           cmd,
  output crsc_pkg::crsc_sts_t           sts
);
  import crsc_pkg::*;

  localparam int IDX_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int ENT_W  = CARD_W + TIME_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  logic [CARD_W-1:0]        card_r;
  logic [TIME_W-1:0]        time_r;
  logic [WIN_W-1:0]         window;
  logic [IDX_W-1:0]         rd_idx;
  logic [IDX_W-1:0]         cmp_idx;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         ptr;
  logic [CACHE_ENTRIES-1:0] valid;
  logic [TIME_W-1:0]        diff;
  logic [ENT_W-1:0]         rdata;
  logic [CARD_W-1:0]        rd_card;
  logic [TIME_W-1:0]        rd_time;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;

  assign rd_card = rdata[ENT_W-1:TIME_W];
  assign rd_time = rdata[TIME_W-1:0];
  assign wr_en   = cmd.wr_hit | cmd.wr_miss;
  assign wr_addr = cmd.wr_miss ? ptr : hit_idx;

  // Entry storage: card identifier over last accepted time
  crsc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({card_r, time_r}),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // Request capture and scan indexes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      card_r <= card_id;
      time_r <= timestamp_ms;
    end
    cmp_idx <= rd_idx;
    if (cmd.load) begin
      rd_idx <= '0;
    end else if (cmd.step && (rd_idx != LAST_IDX)) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
    // elapsed time wraps modulo 2^64
    if (cmd.capture) begin
      diff    <= time_r - rd_time;
      hit_idx <= cmp_idx;
    end
  end

  // Valid marks, replace pointer and window register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      ptr    <= '0;
      window <= WINDOW_RESET;
    end else begin
      if (cfg_valid) begin
        window <= cfg_window;
      end
      if (cmd.wr_miss) begin
        valid[ptr] <= 1'b1;
        ptr        <= (ptr == LAST_IDX) ? '0 : ptr + IDX_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.post) begin
      out_accept <= cmd.post_accept;
      out_cached <= cmd.post_cached;
    end
  end

  // Status
  assign sts.match    = valid[cmp_idx] && (rd_card == card_r);
  assign sts.last     = (cmp_idx == LAST_IDX);
  assign sts.too_soon = (diff[TIME_W-1:WIN_W] == '0) && (diff[WIN_W-1:0] < window);
  assign sts.out_busy = out_valid && !out_ready;

endmodule

[hdl/card_repeat_suppression_cache_top.sv]
// Card repeat suppression cache: valid/ready for scan requests, a result
// register with valid/ready on the output, and a window configuration write
// channel that is always ready. Each scan reads the slots in order from slot 0
// until the first match or the last slot; a match adds a time check and a
// miss writes a new entry at the replace pointer. The next request is taken
// only after the result is posted, and the result stage waits while the
// previous result is untaken. The entry RAM is read one slot per cycle.
// Valid marks reset cleared; no clearing pass.
`timescale 1ns / 1ps
module card_repeat_suppression_cache_top #(
  parameter int CACHE_ENTRIES = crsc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  crsc_scan_if.sink     scan,
  crsc_result_if.source result,
  crsc_cfg_if.sink      cfg
);
  import crsc_pkg::*;

  crsc_cmd_t cmd;
  crsc_sts_t sts;

  assign cfg.ready = 1'b1;

  // Sequencer
  crsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (scan.valid),
    .in_ready (scan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Cache datapath
  crsc_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .card_id      (scan.card_id),
    .timestamp_ms (scan.timestamp_ms),
    .cfg_valid    (cfg.valid),
    .cfg_window   (cfg.debounce_window_ms),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_accept   (result.accept),
    .out_cached   (result.was_cached),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

[tb/sv/crsc_checker.sv]
// crsc_checker: watches the scan, result and window channels of the card repeat
// suppression cache, predicts each verdict and compares it. Depends on crsc_pkg, crsc_ifs.
`timescale 1ns / 1ps
module crsc_checker #(
  parameter int CACHE_ENTRIES = crsc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  crsc_scan_if        scan,
  crsc_result_if      result,
  crsc_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import crsc_pkg::*;

  typedef struct packed {
    logic accept;
    logic was_cached;
  } scan_verdict_t;

  // Predicted cache contents and window
  logic [CARD_W-1:0] slot_card [CACHE_ENTRIES];
  logic [TIME_W-1:0] slot_seen [CACHE_ENTRIES];
  logic              slot_live [CACHE_ENTRIES];
  int unsigned       victim;
  logic [WIN_W-1:0]  window;
  int unsigned       results_seen;

  scan_verdict_t verdict_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  // Lowest live slot holding the card wins; a miss replaces the round-robin victim
  function automatic scan_verdict_t filter_scan(input logic [CARD_W-1:0] card,
                                                input logic [TIME_W-1:0] now);
    scan_verdict_t v;
    for (int s = 0; s < CACHE_ENTRIES; s++) begin
      if (slot_live[s] && slot_card[s] == card) begin
        v.was_cached = 1'b1;
        // elapsed time wraps modulo 2^64, so a clock going backwards looks old
        v.accept = ((now - slot_seen[s]) >= TIME_W'(window));
        if (v.accept) begin
          slot_seen[s] = now;
        end
        return v;
      end
    end
    slot_card[victim] = card;
    slot_seen[victim] = now;
    slot_live[victim] = 1'b1;
    victim = (victim + 1) % CACHE_ENTRIES;
    v.accept     = 1'b1;
    v.was_cached = 1'b0;
    return v;
  endfunction

  // Handshakes sampled at the rising edge; results are taken before new requests
  always @(posedge clk) begin
    scan_verdict_t want;
    if (rst) begin
      for (int s = 0; s < CACHE_ENTRIES; s++) begin
        slot_live[s] = 1'b0;
      end
      victim = 0;
      window = WINDOW_RESET;
      verdict_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (result.accept !== want.accept) begin
            report_mismatch($sformatf("accept %b, expected %b",
                                      result.accept, want.accept));
          end
          if (result.was_cached !== want.was_cached) begin
            report_mismatch($sformatf("was_cached %b, expected %b",
                                      result.was_cached, want.was_cached));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        window = cfg.debounce_window_ms;
      end
      if (scan.valid && scan.ready) begin
        verdict_q.push_back(filter_scan(scan.card_id, scan.timestamp_ms));
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

[tb/sv/testbench.sv]
// testbench: drives card scans and window writes into the repeat suppression
// cache under varied idling and back-pressure. Depends on crsc_pkg, crsc_ifs, crsc_checker.
`timescale 1ns / 1ps
module testbench;
  import crsc_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam int POOL_SIZE     = 12;
  localparam int PHASE_ITEMS   = 383;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crsc_scan_if   scan ();
  crsc_result_if result ();
  crsc_cfg_if    cfg ();

  int unsigned mismatches;
  int unsigned outstanding;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  // Current window, used only to aim timestamps near its edge
  logic [WIN_W-1:0]  window_ms = WINDOW_RESET;
  logic [CARD_W-1:0] card_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_ms;

  card_repeat_suppression_cache_top #(
    .CACHE_ENTRIES(CACHE_ENTRIES_DEF)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan),
    .result (result),
    .cfg    (cfg)
  );

  crsc_checker #(
    .CACHE_ENTRIES(CACHE_ENTRIES_DEF)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .scan        (scan),
    .result      (result),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result ready: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result.ready = 1'b0;
    end else begin
      result.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((scan.valid && scan.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CARD_W-1:0] rand_card();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CARD_W-1:0];
  endfunction

  // Next scan time: mostly around the window edge, sometimes backwards or anywhere
  function automatic logic [TIME_W-1:0] step_time(input logic [TIME_W-1:0] t);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return t + TIME_W'($urandom_range(window_ms));
    end else if (pick < 80) begin
      return t + TIME_W'(window_ms) + TIME_W'($urandom_range(window_ms));
    end else if (pick < 88) begin
      return t + TIME_W'(window_ms) - 64'd1;
    end else if (pick < 94) begin
      return t - TIME_W'($urandom_range(1000, 1));
    end
    return rand_time();
  endfunction

  // One scan request; valid stays high into the next one unless the sender idles
  task automatic send_scan(input logic [CARD_W-1:0] card, input logic [TIME_W-1:0] ts);
    scan.card_id      = card;
    scan.timestamp_ms = ts;
    scan.valid        = 1'b1;
    @(posedge clk);
    while (!scan.ready) @(posedge clk);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      scan.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    scan.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] win);
    wait_drained();
    cfg.debounce_window_ms = win;
    cfg.valid              = 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
    window_ms = win;
  endtask

  // Mostly repeat taps from a small card pool (more cards than slots), some strangers
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic [WIN_W-1:0] win, input bit with_holdoff);
    logic [CARD_W-1:0] card;
    write_window(win);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < POOL_SIZE; i++) begin
      card_pool[i] = rand_card();
    end
    card_pool[0] = '0;
    card_pool[1] = '1;
    clock_ms = rand_time();
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k == PHASE_ITEMS / 2) begin
        wait_drained();
      end
      if (with_holdoff && k == 20) begin
        hold_req = 1'b1;
      end
      if ($urandom_range(99) < 85) begin
        card = card_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        card = rand_card();
      end
      clock_ms = step_time(clock_ms);
      send_scan(card, clock_ms);
    end
  endtask

  initial begin
    scan.valid             = 1'b0;
    scan.card_id           = '0;
    scan.timestamp_ms      = '0;
    cfg.valid              = 1'b0;
    cfg.debounce_window_ms = '0;
    result.ready           = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset window of 2000 ms first
    send_scan('0, 64'd0);              // miss, fills slot 0
    send_scan('0, 64'd1999);           // one short of the window: suppressed
    send_scan('0, 64'd2000);           // exactly the window: accepted, refreshed
    send_scan('1, '1);                 // widest id and time
    send_scan('1, 64'd5);              // time wrapped past zero, still inside
    send_scan('0, 64'd100);            // clock went backwards: accepted
    for (int i = 1; i <= 8; i++) begin
      send_scan(CARD_W'(i), 64'd10000); // full cache, evicts the first two cards
    end
    send_scan('0, 64'd10001);          // evicted card misses again
    send_scan(CARD_W'(5), 64'd10500);  // hit inside the window
    write_window('0);
    send_scan(CARD_W'(3), 64'd10000);  // zero window never suppresses
    write_window('1);
    send_scan(CARD_W'(4), 64'd10000 + 64'hFF_FFFE);
    send_scan(CARD_W'(4), 64'd10000 + 64'hFF_FFFF);

    // Random phases over idling patterns and window settings
    run_phase(0, 0, WINDOW_RESET, 1'b1);
    run_phase(55, 0, '1, 1'b0);
    run_phase(0, 55, WIN_W'($urandom_range(500, 1)), 1'b0);
    run_phase(28, 28, WIN_W'($urandom), 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
